// File: sv/md5e_pkg.sv
// Shared types and constants for the median-of-window distance smoother.
package md5e_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int WINDOW_LEN_DEF = 5;
    localparam int WEIGHT_WIDTH   = 17;
    localparam int FRAC_BITS      = 16;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    typedef logic [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [WEIGHT_WIDTH-1:0] weight_t;

    localparam weight_t WEIGHT_ONE   = weight_t'(1 << FRAC_BITS);
    localparam weight_t WEIGHT_RESET = weight_t'(58982);

    // queue occupancy as seen by the front end and the checks
    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } queue_status_t;

endpackage

// File: sv/md5e_front.sv
// Front end: input transfer, sample window shift and median selection.
module md5e_front
    import md5e_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  sample_t s_distance_sample,
    input  logic    q_full,
    output logic    q_push,
    output sample_t q_data
);

    localparam int RANK_W = $clog2(WINDOW_LEN);
    localparam int MID    = (WINDOW_LEN - 1) / 2;

    sample_t             window_reg  [WINDOW_LEN];
    sample_t             window_next [WINDOW_LEN];
    logic [RANK_W-1:0]   rank        [WINDOW_LEN];

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    always_comb begin
        window_next = window_reg;
        if (q_push) begin
            window_next[0] = s_distance_sample;
            for (int i = 1; i < WINDOW_LEN; i++) begin
                window_next[i] = window_reg[i-1];
            end
        end
    end

    // stable rank: ties broken by position, so the ranks form a permutation
    always_comb begin
        for (int i = 0; i < WINDOW_LEN; i++) begin
            rank[i] = '0;
            for (int j = 0; j < WINDOW_LEN; j++) begin
                if (j != i) begin
                    if ((window_next[j] < window_next[i]) ||
                        ((window_next[j] == window_next[i]) && (j < i))) begin
                        rank[i] = rank[i] + 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        q_data = '0;
        for (int i = 0; i < WINDOW_LEN; i++) begin
            if (rank[i] == RANK_W'(MID)) begin
                q_data = window_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                window_reg[i] <= '0;
            end
        end else begin
            window_reg <= window_next;
        end
    end

endmodule

// File: sv/md5e_queue.sv
// Short queue of medians between the front end and the smoother.
module md5e_queue
    import md5e_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  sample_t       push_data,
    input  logic          pop,
    output sample_t       pop_data,
    output queue_status_t status
);

    sample_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign status.count = count_reg;

    assign do_push  = push && !status.full;
    assign do_pop   = pop && !status.empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: sv/md5e_back.sv
// Back end: exponential smoother and the registered result transfer.
module md5e_back
    import md5e_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_valid,
    input  sample_t q_data,
    output logic    q_pop,
    input  weight_t weight,
    output logic    m_valid,
    input  logic    m_ready,
    output sample_t m_smoothed_distance,
    output sample_t m_median_distance
);

    localparam int DIFF_W   = SAMPLE_WIDTH + 1;
    localparam int PROD_W   = DIFF_W + WEIGHT_WIDTH + 1;
    localparam int STEP_W   = PROD_W - FRAC_BITS;
    localparam int HALF_LSB = 1 << (FRAC_BITS - 1);

    logic                     m_valid_reg;
    logic                     m_valid_next;
    sample_t                  smoothed_reg;
    sample_t                  smoothed_next;
    sample_t                  median_reg;
    weight_t                  w_sat;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] acc;
    logic signed [STEP_W-1:0] step;
    logic signed [STEP_W-1:0] sum;

    assign q_pop = q_valid && (!m_valid_reg || m_ready);

    // prev + round(w * (median - prev)), same as the weighted mean with rounding
    always_comb begin
        w_sat = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
        diff  = $signed({1'b0, q_data}) - $signed({1'b0, smoothed_reg});
        prod  = PROD_W'($signed({1'b0, w_sat})) * PROD_W'(diff);
        acc   = prod + PROD_W'(HALF_LSB);
        step  = $signed(acc[PROD_W-1:FRAC_BITS]);
        sum   = step + $signed({{(STEP_W - SAMPLE_WIDTH){1'b0}}, smoothed_reg});
        smoothed_next = sum[SAMPLE_WIDTH-1:0];
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (q_pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            smoothed_reg <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (q_pop) begin
                smoothed_reg <= smoothed_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            median_reg <= q_data;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_smoothed_distance = smoothed_reg;
    assign m_median_distance   = median_reg;

endmodule

// File: sv/median5_ema_distance_filter_unit.sv
// Top level: median spike filter followed by an exponential distance smoother.
//
// Each distance sample (unsigned Q10.6 cm) taken on the s_ channel is shifted
// into a window of WINDOW_LEN entries, newest first; the median of the window
// (lower middle for an even length) rejects isolated spikes and is then
// smoothed as round(w*median + (1-w)*previous) with w the Q1.16 weight in the
// configuration register (reset 58982, about 0.9; anything above 1.0 is taken
// as 1.0, which passes the median straight through). Each input transfer gives
// exactly one m_ transfer carrying the smoothed value and the median. Window
// and smoother start at zero, so the zeros take part in the median until they
// have been shifted out. The block takes one sample per clock while the queue
// has room: the front end does the window shift and a rank-based median
// selection in the cycle of the transfer and pushes the median into a
// two-entry queue; the back end pops it once the output register is free and
// does one signed multiply and add against the stored smoothed value into
// the output register. Throughput is one sample per clock while neither side
// stalls, set by the multiply-add loop. The queue and the output register let
// either side stall without starving the other. The weight may only be
// written while no sample is in flight.
module median5_ema_distance_filter_unit
    import md5e_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    cfg_wr_en,
    input  weight_t cfg_wr_data,
    input  logic    s_valid,
    output logic    s_ready,
    input  sample_t s_distance_sample,
    output logic    m_valid,
    input  logic    m_ready,
    output sample_t m_smoothed_distance,
    output sample_t m_median_distance
);

    weight_t       weight_reg;
    logic          q_push;
    sample_t       q_push_data;
    logic          q_pop;
    sample_t       q_pop_data;
    queue_status_t q_status;

    // smoothing weight, Q1.16
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= WEIGHT_RESET;
        end else if (cfg_wr_en) begin
            weight_reg <= cfg_wr_data;
        end
    end

    md5e_front #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_distance_sample (s_distance_sample),
        .q_full            (q_status.full),
        .q_push            (q_push),
        .q_data            (q_push_data)
    );

    md5e_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .status    (q_status)
    );

    md5e_back u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .q_valid             (!q_status.empty),
        .q_data              (q_pop_data),
        .q_pop               (q_pop),
        .weight              (weight_reg),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_smoothed_distance (m_smoothed_distance),
        .m_median_distance   (m_median_distance)
    );

    // reset leaves no result pending
    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // the smoother only takes a median when the output register is free
    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (!m_valid || m_ready))
        else $error("pending result overwritten");

    // a sample transfer always finds room in the queue
    a_push_fits_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (q_status.count < QCNT_W'(QUEUE_DEPTH)))
        else $error("median pushed into a full queue");

    // occupancy rises by one on a push without a pop
    a_queue_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && !q_pop) |=> (q_status.count == $past(q_status.count) + 1'b1))
        else $error("queue count lost a push");

endmodule
